FILE: src/vfcm_pkg.sv
// Shared types and constants for the voxel face-culling mesher.
// Holds the input and face word structs, opcodes and face direction codes.
// No dependencies.
package vfcm_pkg;

	// Fixed field widths
	localparam int OP_W     = 2;
	localparam int COORD_XW = 4;
	localparam int COORD_YW = 8;
	localparam int COORD_ZW = 4;
	localparam int BTYPE_W  = 8;
	localparam int AIR_W    = 8;
	localparam int DIR_W    = 3;
	localparam int COUNT_W  = 19;
	localparam int VBASE_W  = 21;
	localparam int NUM_DIRS = 6;

	// Opcodes
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_MESH  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// Face directions, in emission order
	localparam logic [DIR_W-1:0] DIR_PZ = 3'd0;
	localparam logic [DIR_W-1:0] DIR_NZ = 3'd1;
	localparam logic [DIR_W-1:0] DIR_PY = 3'd2;
	localparam logic [DIR_W-1:0] DIR_NY = 3'd3;
	localparam logic [DIR_W-1:0] DIR_PX = 3'd4;
	localparam logic [DIR_W-1:0] DIR_NX = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]     opcode;
		logic [COORD_XW-1:0] cell_x;
		logic [COORD_YW-1:0] cell_y;
		logic [COORD_ZW-1:0] cell_z;
		logic [BTYPE_W-1:0]  block_type;
	} item_t;

	typedef struct packed {
		logic [COORD_XW-1:0] face_x;
		logic [COORD_YW-1:0] face_y;
		logic [COORD_ZW-1:0] face_z;
		logic [DIR_W-1:0]    face_dir;
		logic [VBASE_W-1:0]  vertex_base;
		logic                last_face;
	} face_t;

endpackage

FILE: src/vfcm_ram.sv
// Generic single-port RAM with registered read data.
// One address per cycle, write or read; read returns the old contents.
// No dependencies.
module vfcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Storage array and read register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: src/voxel_face_culling_mesher.sv
// Voxel face-culling mesher top level: chunk store, neighbor read sequencer, face emitter.
// Depends on vfcm_pkg (types, codes) and vfcm_ram (chunk store).
//
//  channel | signals                   | dir | word
//  --------+---------------------------+-----+---------------------------------
//  item    | item_valid/item_ready     | in  | opcode, cell x/y/z, block_type
//  face    | face_valid/face_ready     | out | face x/y/z, dir, vertex base, last
//  cfg     | cfg_we/cfg_wdata          | in  | air code, no handshake wait
//
// Write, clear and no-op words leave the sequencer idle. A mesh word holds item_ready
// low, once taken, through 7 reads (cell plus six neighbors through the one RAM
// port) and a decision step; an exposed cell then emits one face per load of the
// face register, which waits while a face is pending and face_ready is low.
// After reset the store is swept to code zero, one cell per cycle, over all
// 2^(2*clog2(CHUNK_WIDTH)+clog2(CHUNK_HEIGHT)) cells (65536 by default);
// item_ready stays low during the sweep. The face register lets the next
// word in while the final face still waits.
module voxel_face_culling_mesher #(
	parameter int CHUNK_WIDTH  = 16,
	parameter int CHUNK_HEIGHT = 256,
	parameter int TYPE_BITS    = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [vfcm_pkg::AIR_W-1:0]    cfg_wdata,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  vfcm_pkg::item_t               item,
	output logic                          face_valid,
	input  logic                          face_ready,
	output vfcm_pkg::face_t               face
);

	localparam int XW    = $clog2(CHUNK_WIDTH);
	localparam int YW    = $clog2(CHUNK_HEIGHT);
	localparam int AW    = 2 * XW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int CMPW  = (TYPE_BITS > vfcm_pkg::AIR_W) ? TYPE_BITS : vfcm_pkg::AIR_W;
	localparam int ND    = vfcm_pkg::NUM_DIRS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LAST,
		ST_EMIT
	} state_t;

	state_t                          st_q;
	logic [2:0]                      idx_q;
	logic                            clr_active_q;
	logic [AW-1:0]                   clr_addr_q;
	logic [vfcm_pkg::AIR_W-1:0]      air_q;
	logic [vfcm_pkg::COUNT_W-1:0]    face_cnt_q;
	logic [ND-1:0]                   mask_q;
	logic [ND-1:0]                   air_flags_q;
	logic [vfcm_pkg::COORD_XW-1:0]   cx_q;
	logic [vfcm_pkg::COORD_YW-1:0]   cy_q;
	logic [vfcm_pkg::COORD_ZW-1:0]   cz_q;
	logic                            out_valid_q;
	vfcm_pkg::face_t                 face_q;

	logic                            item_fire;
	logic                            item_in_chunk;
	logic [AW-1:0]                   ram_addr;
	logic                            ram_we;
	logic [TYPE_BITS-1:0]            ram_wdata;
	logic [TYPE_BITS-1:0]            ram_rdata;
	logic                            ram_hit;
	logic [XW-1:0]                   xe;
	logic [YW-1:0]                   ye;
	logic [XW-1:0]                   ze;
	logic [AW-1:0]                   rd_addr_tab [ND+1];
	logic [ND-1:0]                   at_edge;
	logic                            up_ok;
	logic [ND:0]                     air_now;
	logic [ND-1:0]                   emit_vec;
	logic                            exposed;
	logic [ND-1:0]                   sel;
	logic [vfcm_pkg::DIR_W-1:0]      sel_dir;
	logic                            out_load;

	function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
			input logic [YW-1:0] y, input logic [XW-1:0] z);
		return {x, y, z};
	endfunction

	assign item_ready = (st_q == ST_IDLE) && !clr_active_q;
	assign item_fire  = item_valid && item_ready;
	assign item_in_chunk = (32'(item.cell_x) < CHUNK_WIDTH) &&
		(32'(item.cell_y) < CHUNK_HEIGHT) && (32'(item.cell_z) < CHUNK_WIDTH);

	// Held cell coordinates at store width
	assign xe = XW'(cx_q);
	assign ye = YW'(cy_q);
	assign ze = XW'(cz_q);

	// Read slots: cell first, then neighbors in face order
	assign rd_addr_tab[0] = cell_addr(xe, ye, ze);
	assign rd_addr_tab[1] = cell_addr(xe, ye, ze + XW'(1));
	assign rd_addr_tab[2] = cell_addr(xe, ye, ze - XW'(1));
	assign rd_addr_tab[3] = cell_addr(xe, ye + YW'(1), ze);
	assign rd_addr_tab[4] = cell_addr(xe, ye - YW'(1), ze);
	assign rd_addr_tab[5] = cell_addr(xe + XW'(1), ye, ze);
	assign rd_addr_tab[6] = cell_addr(xe - XW'(1), ye, ze);

	// Chunk edge per face direction
	assign at_edge[vfcm_pkg::DIR_PZ] = (ze == XW'(CHUNK_WIDTH - 1));
	assign at_edge[vfcm_pkg::DIR_NZ] = (ze == '0);
	assign at_edge[vfcm_pkg::DIR_PY] = (ye == YW'(CHUNK_HEIGHT - 1));
	assign at_edge[vfcm_pkg::DIR_NY] = (ye == '0);
	assign at_edge[vfcm_pkg::DIR_PX] = (xe == XW'(CHUNK_WIDTH - 1));
	assign at_edge[vfcm_pkg::DIR_NX] = (xe == '0);
	// Upward neighbor only counts for exposure below height minus three
	assign up_ok = (ye < YW'(CHUNK_HEIGHT - 3));

	// Shared air compare on the RAM read port
	assign ram_hit = (CMPW'(ram_rdata) == CMPW'(air_q));
	// Bit 0 is the cell itself, bit d+1 the neighbor on face d
	assign air_now = {ram_hit, air_flags_q};

	// Face mask and exposure
	always_comb begin
		exposed = 1'b0;
		for (int d = 0; d < ND; d++) begin
			emit_vec[d] = at_edge[d] | air_now[d+1];
			if (!at_edge[d] && air_now[d+1] &&
					(up_ok || (d != int'(vfcm_pkg::DIR_PY)))) begin
				exposed = 1'b1;
			end
		end
	end

	// Lowest pending face and its code
	assign sel = mask_q & (~mask_q + ND'(1));
	always_comb begin
		sel_dir = '0;
		for (int d = 0; d < ND; d++) begin
			if (sel[d]) begin
				sel_dir = sel_dir | vfcm_pkg::DIR_W'(d);
			end
		end
	end

	assign out_load = (st_q == ST_EMIT) && (!out_valid_q || face_ready);

	// RAM port: clearing sweep, block write, or neighbor read
	always_comb begin
		ram_addr  = rd_addr_tab[idx_q];
		ram_we    = 1'b0;
		ram_wdata = '0;
		if (clr_active_q) begin
			ram_addr = clr_addr_q;
			ram_we   = 1'b1;
		end else if (item_fire && item.opcode == vfcm_pkg::OP_WRITE && item_in_chunk) begin
			ram_addr  = cell_addr(XW'(item.cell_x), YW'(item.cell_y), XW'(item.cell_z));
			ram_we    = 1'b1;
			ram_wdata = TYPE_BITS'(item.block_type);
		end
	end

	vfcm_ram #(
		.WIDTH(TYPE_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.addr (ram_addr),
		.we   (ram_we),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Sequencer, counters and face register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			idx_q        <= '0;
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
			air_q        <= '0;
			face_cnt_q   <= '0;
			mask_q       <= '0;
			air_flags_q  <= '0;
			cx_q         <= '0;
			cy_q         <= '0;
			cz_q         <= '0;
			out_valid_q  <= 1'b0;
			face_q       <= '0;
		end else begin
			if (cfg_we) begin
				air_q <= cfg_wdata;
			end
			if (clr_active_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == '1) begin
					clr_active_q <= 1'b0;
				end
			end
			// Face register valid: set on load, cleared when taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (face_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (item_fire) begin
						cx_q  <= item.cell_x;
						cy_q  <= item.cell_y;
						cz_q  <= item.cell_z;
						idx_q <= '0;
						if (item.opcode == vfcm_pkg::OP_CLEAR) begin
							face_cnt_q <= '0;
						end
						if (item.opcode == vfcm_pkg::OP_MESH && item_in_chunk) begin
							st_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (idx_q != '0) begin
						air_flags_q[idx_q - 3'd1] <= ram_hit;
					end
					if (idx_q == 3'(ND)) begin
						st_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				ST_LAST: begin
					if (!air_now[0] && exposed) begin
						mask_q <= emit_vec;
						st_q   <= ST_EMIT;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						face_q.face_x      <= cx_q;
						face_q.face_y      <= cy_q;
						face_q.face_z      <= cz_q;
						face_q.face_dir    <= sel_dir;
						face_q.vertex_base <= {face_cnt_q, 2'b00};
						face_q.last_face   <= ((mask_q & ~sel) == '0);
						face_cnt_q         <= face_cnt_q + vfcm_pkg::COUNT_W'(1);
						mask_q             <= mask_q & ~sel;
						if ((mask_q & ~sel) == '0) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign face_valid = out_valid_q;
	assign face       = face_q;

`ifndef SYNTHESIS
	a_no_item_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !item_ready)
		else $error("item taken during store clearing sweep");

	a_emit_has_face: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT) |-> (mask_q != '0))
		else $error("emit state with no pending face");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (face_cnt_q == $past(face_cnt_q) + vfcm_pkg::COUNT_W'(1)))
		else $error("face count did not advance by one per face");

	a_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (clr_active_q || st_q == ST_IDLE))
		else $error("store written while meshing a cell");

	a_last_ends_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && ((mask_q & ~sel) == '0)) |=> (st_q == ST_IDLE && face_q.last_face))
		else $error("final face not flagged or sequencer not released");
`endif

endmodule
